// ===== rtl/core/rigid_pose_change_metric_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the rigid pose change metric
// Short forms for the concurrent checks used in the core's RTL.
// ----------------------------------------------------------------------------
`ifndef RIGID_POSE_CHANGE_METRIC_MACROS_SVH
`define RIGID_POSE_CHANGE_METRIC_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RPCM_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rpcm: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define RPCM_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rpcm: next-cycle check failed");

`endif

// ===== rtl/core/rpcm_pkg.sv =====
// ----------------------------------------------------------------------------
// Rigid pose change metric package
// Widths, command codes, sequencer types and the request and response
// structures of the shared CORDIC and square root units.
// ----------------------------------------------------------------------------
`default_nettype none

package rpcm_pkg;

   // Fixed-point format and iteration counts.
   localparam int FRAC_BITS    = 16;
   localparam int CORDIC_STEPS = 20;
   localparam int STEP_W       = $clog2(CORDIC_STEPS);

   // Field and datapath widths.
   localparam int CMD_W      = 2;
   localparam int IDX_W      = 4;
   localparam int WORD_W     = 32;
   localparam int OUT_W      = 31;
   localparam int POSE_ELEMS = 12;
   localparam int OPND_W     = WORD_W + 1;
   localparam int ACC_W      = 2 * OPND_W;
   localparam int XY_W       = 50;
   localparam int CW         = XY_W + 2;
   localparam int SIN_W      = FRAC_BITS + 2;
   localparam int SQ_W       = 64;
   localparam int ROOT_W     = 32;
   localparam int ROOT_CNT_W = $clog2(ROOT_W);

   // CORDIC gain compensation, Q30 scaled down to the working format.
   localparam logic [WORD_W-1:0] KINV_Q30 = 32'h26DD3B6A;
   localparam logic [WORD_W-1:0] KINV     = KINV_Q30 >> (30 - FRAC_BITS);

   // Command codes.
   localparam logic [CMD_W-1:0] CMD_LOAD_REF = 2'd0;
   localparam logic [CMD_W-1:0] CMD_LOAD_UPD = 2'd1;
   localparam logic [CMD_W-1:0] CMD_COMPUTE  = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIFF,
      ST_MUL,
      ST_ACC,
      ST_CORDIC,
      ST_SQRT,
      ST_SEND
   } state_type;

   typedef enum logic [2:0] {
      JOB_MAT,
      JOB_S0,
      JOB_C2,
      JOB_S1,
      JOB_XY,
      JOB_S2,
      JOB_SN,
      JOB_TN
   } job_type;

   typedef struct packed {
      logic                   start;
      logic signed [XY_W-1:0] x;
      logic signed [XY_W-1:0] y;
   } cordic_req_type;

   typedef struct packed {
      logic             done;
      logic [SIN_W-1:0] sine;
   } cordic_rsp_type;

   typedef struct packed {
      logic            start;
      logic [SQ_W-1:0] value;
   } sqrt_req_type;

   typedef struct packed {
      logic              done;
      logic [ROOT_W-1:0] root;
   } sqrt_rsp_type;

endpackage

`default_nettype wire

// ===== rtl/core/rpcm_channels.sv =====
// ----------------------------------------------------------------------------
// Rigid pose change metric channels
// Valid/ready channels for the command words and the result words.
// ----------------------------------------------------------------------------
`default_nettype none

interface rpcm_req_if;
   import rpcm_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [CMD_W-1:0]         command;
   logic [IDX_W-1:0]         element_index;
   logic signed [WORD_W-1:0] element_value;

   modport source (output valid, output command, output element_index,
                   output element_value, input ready);
   modport sink   (input valid, input command, input element_index,
                   input element_value, output ready);
endinterface

interface rpcm_rsp_if;
   import rpcm_pkg::*;

   logic             valid;
   logic             ready;
   logic [OUT_W-1:0] pose_change;

   modport source (output valid, output pose_change, input ready);
   modport sink   (input valid, input pose_change, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/rpcm_cordic.sv =====
// ----------------------------------------------------------------------------
// Rigid pose change metric CORDIC unit
// Vectoring CORDIC that returns the magnitude of the sine of the angle of
// (x, y), one micro-rotation per cycle, with a companion vector.
// ----------------------------------------------------------------------------
`default_nettype none

module rpcm_cordic (
   input  logic                    clock,
   input  logic                    reset,
   input  rpcm_pkg::cordic_req_type cordic_req,
   output rpcm_pkg::cordic_rsp_type cordic_rsp
);
   import rpcm_pkg::*;

   logic signed [CW-1:0] vx_ff, vx_in, vy_ff, vy_in, c_ff, c_in, s_ff, s_in;
   logic [STEP_W-1:0]    step_ff, step_in;
   logic                 busy_ff, busy_in, done_ff, done_in;
   logic [SIN_W-1:0]     sine_ff, sine_in;
   logic signed [CW-1:0] ax, ay, dx, dy, dc, ds, s_abs;

   // Operand magnitudes and the shifted terms of the current step.
   always_comb begin
      ax = {{(CW-XY_W){cordic_req.x[XY_W-1]}}, cordic_req.x};
      ay = {{(CW-XY_W){cordic_req.y[XY_W-1]}}, cordic_req.y};
      if (ax[CW-1]) begin
         ax = -ax;
      end
      if (ay[CW-1]) begin
         ay = -ay;
      end
      dx = vy_ff >>> step_ff;
      dy = vx_ff >>> step_ff;
      dc = s_ff >>> step_ff;
      ds = c_ff >>> step_ff;
   end

   // One micro-rotation per cycle while busy; a new start loads the vectors.
   always_comb begin
      vx_in   = vx_ff;
      vy_in   = vy_ff;
      c_in    = c_ff;
      s_in    = s_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      sine_in = sine_ff;
      s_abs   = '0;
      if (busy_ff) begin
         if (!vy_ff[CW-1]) begin
            vx_in = vx_ff + dx;
            vy_in = vy_ff - dy;
            c_in  = c_ff - dc;
            s_in  = s_ff + ds;
         end else begin
            vx_in = vx_ff - dx;
            vy_in = vy_ff + dy;
            c_in  = c_ff + dc;
            s_in  = s_ff - ds;
         end
         step_in = step_ff + 1'b1;
         s_abs   = s_in[CW-1] ? -s_in : s_in;
         if (step_ff == STEP_W'(CORDIC_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            sine_in = s_abs[SIN_W-1:0];
         end
      end else if (cordic_req.start) begin
         if (ax == '0 && ay == '0) begin
            // The angle of the null vector is taken as zero.
            sine_in = '0;
            done_in = 1'b1;
         end else begin
            vx_in   = ax;
            vy_in   = ay;
            c_in    = CW'(KINV);
            s_in    = '0;
            step_in = '0;
            busy_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      vx_ff   <= vx_in;
      vy_ff   <= vy_in;
      c_ff    <= c_in;
      s_ff    <= s_in;
      step_ff <= step_in;
      sine_ff <= sine_in;
   end

   assign cordic_rsp.done = done_ff;
   assign cordic_rsp.sine = sine_ff;

endmodule

`default_nettype wire

// ===== rtl/core/rpcm_isqrt.sv =====
// ----------------------------------------------------------------------------
// Rigid pose change metric square root unit
// Floor square root of a 64-bit unsigned word, one result bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rpcm_isqrt (
   input  logic                  clock,
   input  logic                  reset,
   input  rpcm_pkg::sqrt_req_type sqrt_req,
   output rpcm_pkg::sqrt_rsp_type sqrt_rsp
);
   import rpcm_pkg::*;

   logic [SQ_W-1:0]       v_ff, v_in, r_ff, r_in, bit_ff, bit_in, trial;
   logic [ROOT_CNT_W-1:0] cnt_ff, cnt_in;
   logic                  busy_ff, busy_in, done_ff, done_in;
   logic [ROOT_W-1:0]     root_ff, root_in;

   // Digit-by-digit recurrence: subtract the trial value where it fits.
   always_comb begin
      v_in    = v_ff;
      r_in    = r_ff;
      bit_in  = bit_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      root_in = root_ff;
      trial   = r_ff + bit_ff;
      if (busy_ff) begin
         if (v_ff >= trial) begin
            v_in = v_ff - trial;
            r_in = (r_ff >> 1) + bit_ff;
         end else begin
            r_in = r_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == ROOT_CNT_W'(ROOT_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            root_in = r_in[ROOT_W-1:0];
         end
      end else if (sqrt_req.start) begin
         v_in    = sqrt_req.value;
         r_in    = '0;
         bit_in  = {2'b01, {(SQ_W-2){1'b0}}};
         cnt_in  = '0;
         busy_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      v_ff    <= v_in;
      r_ff    <= r_in;
      bit_ff  <= bit_in;
      cnt_ff  <= cnt_in;
      root_ff <= root_in;
   end

   assign sqrt_rsp.done = done_ff;
   assign sqrt_rsp.root = root_ff;

endmodule

`default_nettype wire

// ===== rtl/core/rigid_pose_change_metric.sv =====
// ----------------------------------------------------------------------------
// Rigid pose change metric
// Holds a reference pose and an updated pose and, on command, measures how
// far the updated pose has moved and turned from the reference.
//
// The request channel carries one word per transfer: a load of one element
// of either pose (index 12 to 15 ignored), or a compute command.
// Unknown commands are taken and dropped. A compute uses one shared
// multiply-accumulate unit (36 matrix products), three passes of a
// 20-step CORDIC unit and three passes of a 32-step square root unit,
// all run in turn by the sequencer. The request channel is not ready
// during a compute. One result word comes out per compute through an
// output register: the next request is taken while the result still
// waits, and only a later result has to wait for the receiver.
// Reset clears both poses to zero and empties the output register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "rigid_pose_change_metric_macros.svh"

module rigid_pose_change_metric (
   input  logic      clock,
   input  logic      reset,
   rpcm_req_if.sink   req_chan,
   rpcm_rsp_if.source rsp_chan
);
   import rpcm_pkg::*;

   localparam logic [1:0] TCOL = 2'd3;

   // Sequencer state.
   state_type state_ff, state_in;
   job_type   job_ff, job_in;
   logic [1:0] i_ff, i_in, j_ff, j_in, k_ff, k_in;

   // Pose stores and intermediate results.
   logic signed [WORD_W-1:0] ref_pose_ff [POSE_ELEMS];
   logic signed [WORD_W-1:0] upd_pose_ff [POSE_ELEMS];
   logic signed [OPND_W-1:0] diff_ff [3];
   logic signed [WORD_W-1:0] m_ff [3][3];
   logic signed [WORD_W-1:0] d_ff [3];
   logic [SIN_W-1:0]         s0_ff, s0_in, s1_ff, s1_in, s2_ff, s2_in;
   logic signed [XY_W-1:0]   y2_ff, y2_in;
   logic [ROOT_W-1:0]        sn_ff, sn_in, tn_ff, tn_in;

   // Multiply-accumulate unit.
   logic signed [OPND_W-1:0] mac_a, mac_b;
   logic                     mac_frac, mac_sub;
   logic signed [ACC_W-1:0]  prod_ff, prod_in, acc_ff, acc_in, addend, acc_sum;
   logic [ACC_W-WORD_W:0]    acc_top;
   logic signed [WORD_W-1:0] sat_word;

   // Output register.
   logic             rsp_valid_ff, rsp_valid_in;
   logic [OUT_W-1:0] rsp_data_ff, rsp_data_in;
   logic [ROOT_W:0]  metric_sum;

   logic                     req_accept, ref_we, upd_we, diff_we, m_we, d_we;
   logic [IDX_W-1:0]         ref_idx, upd_idx;
   logic signed [WORD_W-1:0] ref_rd, upd_rd;
   logic                     last_term;

   cordic_req_type cordic_req;
   cordic_rsp_type cordic_rsp;
   sqrt_req_type   sqrt_req;
   sqrt_rsp_type   sqrt_rsp;

   rpcm_cordic u_cordic (
      .clock      (clock),
      .reset      (reset),
      .cordic_req (cordic_req),
      .cordic_rsp (cordic_rsp)
   );

   rpcm_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .sqrt_req (sqrt_req),
      .sqrt_rsp (sqrt_rsp)
   );

   // Pose reads: row k, column i or j, or the translation column.
   assign ref_idx = {k_ff, (state_ff == ST_DIFF) ? TCOL : j_ff};
   assign upd_idx = {k_ff, (state_ff == ST_DIFF) ? TCOL : i_ff};
   assign ref_rd  = ref_pose_ff[ref_idx];
   assign upd_rd  = upd_pose_ff[upd_idx];

   // Operands of the shared multiplier, chosen by job and term.
   always_comb begin
      mac_a    = '0;
      mac_b    = '0;
      mac_frac = 1'b1;
      mac_sub  = 1'b0;
      unique case (job_ff)
         JOB_MAT: begin
            mac_a = {upd_rd[WORD_W-1], upd_rd};
            mac_b = (j_ff == TCOL) ? diff_ff[k_ff] : {ref_rd[WORD_W-1], ref_rd};
         end
         JOB_C2: begin
            mac_frac = 1'b0;
            mac_a    = (k_ff == 2'd0) ? {m_ff[0][0][WORD_W-1], m_ff[0][0]}
                                      : {m_ff[0][1][WORD_W-1], m_ff[0][1]};
            mac_b    = mac_a;
         end
         JOB_XY: begin
            unique case (k_ff)
               2'd0: begin
                  mac_a = {m_ff[1][2][WORD_W-1], m_ff[1][2]};
                  mac_b = {m_ff[2][0][WORD_W-1], m_ff[2][0]};
               end
               2'd1: begin
                  mac_a   = {m_ff[2][2][WORD_W-1], m_ff[2][2]};
                  mac_b   = {m_ff[1][0][WORD_W-1], m_ff[1][0]};
                  mac_sub = 1'b1;
               end
               2'd2: begin
                  mac_a = {m_ff[2][2][WORD_W-1], m_ff[2][2]};
                  mac_b = {m_ff[1][1][WORD_W-1], m_ff[1][1]};
               end
               default: begin
                  mac_a   = {m_ff[1][2][WORD_W-1], m_ff[1][2]};
                  mac_b   = {m_ff[2][1][WORD_W-1], m_ff[2][1]};
                  mac_sub = 1'b1;
               end
            endcase
         end
         JOB_SN: begin
            mac_frac = 1'b0;
            unique case (k_ff)
               2'd0:    mac_a = {{(OPND_W-SIN_W){1'b0}}, s0_ff};
               2'd1:    mac_a = {{(OPND_W-SIN_W){1'b0}}, s1_ff};
               default: mac_a = {{(OPND_W-SIN_W){1'b0}}, s2_ff};
            endcase
            mac_b = mac_a;
         end
         JOB_TN: begin
            mac_frac = 1'b0;
            mac_a    = {d_ff[k_ff][WORD_W-1], d_ff[k_ff]};
            mac_b    = mac_a;
         end
         default: begin
            mac_a = '0;
            mac_b = '0;
         end
      endcase
   end

   // Accumulation of the registered product, and saturation to a word.
   always_comb begin
      prod_in  = mac_a * mac_b;
      addend   = mac_frac ? (prod_ff >>> FRAC_BITS) : prod_ff;
      acc_sum  = mac_sub ? (acc_ff - addend) : (acc_ff + addend);
      acc_top  = acc_sum[ACC_W-1:WORD_W-1];
      sat_word = acc_sum[WORD_W-1:0];
      if (acc_top != '0 && acc_top != '1) begin
         sat_word = acc_sum[ACC_W-1] ? {1'b1, {(WORD_W-1){1'b0}}}
                                     : {1'b0, {(WORD_W-1){1'b1}}};
      end
      unique case (job_ff)
         JOB_C2:  last_term = (k_ff == 2'd1);
         JOB_XY:  last_term = (k_ff == 2'd3);
         default: last_term = (k_ff == 2'd2);
      endcase
      metric_sum = {1'b0, sn_ff} + {1'b0, tn_ff};
   end

   assign req_accept = req_chan.valid && req_chan.ready;

   // Sequencer: next state, unit starts and register enables.
   always_comb begin
      state_in     = state_ff;
      job_in       = job_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      k_in         = k_ff;
      acc_in       = acc_ff;
      s0_in        = s0_ff;
      s1_in        = s1_ff;
      s2_in        = s2_ff;
      y2_in        = y2_ff;
      sn_in        = sn_ff;
      tn_in        = tn_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      ref_we       = 1'b0;
      upd_we       = 1'b0;
      diff_we      = 1'b0;
      m_we         = 1'b0;
      d_we         = 1'b0;
      cordic_req   = '0;
      sqrt_req     = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               unique case (req_chan.command)
                  CMD_LOAD_REF: ref_we = (req_chan.element_index < IDX_W'(POSE_ELEMS));
                  CMD_LOAD_UPD: upd_we = (req_chan.element_index < IDX_W'(POSE_ELEMS));
                  CMD_COMPUTE: begin
                     state_in = ST_DIFF;
                     k_in     = '0;
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_DIFF: begin
            diff_we = 1'b1;
            k_in    = k_ff + 1'b1;
            if (k_ff == 2'd2) begin
               state_in = ST_MUL;
               job_in   = JOB_MAT;
               i_in     = '0;
               j_in     = '0;
               k_in     = '0;
               acc_in   = '0;
            end
         end
         ST_MUL: begin
            state_in = ST_ACC;
         end
         ST_ACC: begin
            acc_in   = acc_sum;
            k_in     = k_ff + 1'b1;
            state_in = ST_MUL;
            if (job_ff == JOB_XY && k_ff == 2'd1) begin
               // The sine term of the third angle is complete.
               y2_in  = acc_sum[XY_W-1:0];
               acc_in = '0;
            end
            if (last_term) begin
               acc_in = '0;
               k_in   = '0;
               unique case (job_ff)
                  JOB_MAT: begin
                     m_we = (j_ff != TCOL);
                     d_we = (j_ff == TCOL);
                     j_in = j_ff + 1'b1;
                     if (j_ff == TCOL) begin
                        i_in = i_ff + 1'b1;
                        if (i_ff == 2'd2) begin
                           job_in       = JOB_S0;
                           state_in     = ST_CORDIC;
                           cordic_req.start = 1'b1;
                           cordic_req.x = {{(XY_W-WORD_W){m_ff[2][2][WORD_W-1]}}, m_ff[2][2]};
                           cordic_req.y = {{(XY_W-WORD_W){m_ff[1][2][WORD_W-1]}}, m_ff[1][2]};
                        end
                     end
                  end
                  JOB_XY: begin
                     job_in       = JOB_S2;
                     state_in     = ST_CORDIC;
                     cordic_req.start = 1'b1;
                     cordic_req.x = acc_sum[XY_W-1:0];
                     cordic_req.y = y2_ff;
                  end
                  default: begin
                     state_in       = ST_SQRT;
                     sqrt_req.start = 1'b1;
                     sqrt_req.value = acc_sum[SQ_W-1:0];
                  end
               endcase
            end
         end
         ST_CORDIC: begin
            if (cordic_rsp.done) begin
               k_in   = '0;
               acc_in = '0;
               unique case (job_ff)
                  JOB_S0: begin
                     s0_in    = cordic_rsp.sine;
                     job_in   = JOB_C2;
                     state_in = ST_MUL;
                  end
                  JOB_S1: begin
                     s1_in  = cordic_rsp.sine;
                     job_in = JOB_XY;
                     if (m_ff[1][2] == '0 && m_ff[2][2] == '0) begin
                        // First angle is zero: the third comes from the
                        // second row directly.
                        job_in       = JOB_S2;
                        cordic_req.start = 1'b1;
                        cordic_req.x = {{(XY_W-WORD_W){m_ff[1][1][WORD_W-1]}}, m_ff[1][1]};
                        cordic_req.y = -{{(XY_W-WORD_W){m_ff[1][0][WORD_W-1]}}, m_ff[1][0]};
                     end else begin
                        state_in = ST_MUL;
                     end
                  end
                  default: begin
                     s2_in    = cordic_rsp.sine;
                     job_in   = JOB_SN;
                     state_in = ST_MUL;
                  end
               endcase
            end
         end
         ST_SQRT: begin
            if (sqrt_rsp.done) begin
               unique case (job_ff)
                  JOB_C2: begin
                     job_in       = JOB_S1;
                     state_in     = ST_CORDIC;
                     cordic_req.start = 1'b1;
                     cordic_req.x = {{(XY_W-ROOT_W){1'b0}}, sqrt_rsp.root};
                     cordic_req.y = {{(XY_W-WORD_W){m_ff[0][2][WORD_W-1]}}, m_ff[0][2]};
                  end
                  JOB_SN: begin
                     sn_in    = sqrt_rsp.root;
                     job_in   = JOB_TN;
                     state_in = ST_MUL;
                  end
                  default: begin
                     tn_in    = sqrt_rsp.root;
                     state_in = ST_SEND;
                  end
               endcase
            end
         end
         ST_SEND: begin
            // Wait for the output register to be free, then load the word.
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = (metric_sum[ROOT_W:OUT_W] != '0) ? '1
                                                               : metric_sum[OUT_W-1:0];
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         job_ff       <= JOB_MAT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         job_ff       <= job_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Pose stores, cleared at reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int n = 0; n < POSE_ELEMS; n++) begin
            ref_pose_ff[n] <= '0;
            upd_pose_ff[n] <= '0;
         end
      end else begin
         if (ref_we) begin
            ref_pose_ff[req_chan.element_index] <= req_chan.element_value;
         end
         if (upd_we) begin
            upd_pose_ff[req_chan.element_index] <= req_chan.element_value;
         end
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      i_ff        <= i_in;
      j_ff        <= j_in;
      k_ff        <= k_in;
      prod_ff     <= prod_in;
      acc_ff      <= acc_in;
      s0_ff       <= s0_in;
      s1_ff       <= s1_in;
      s2_ff       <= s2_in;
      y2_ff       <= y2_in;
      sn_ff       <= sn_in;
      tn_ff       <= tn_in;
      rsp_data_ff <= rsp_data_in;
      if (diff_we) begin
         diff_ff[k_ff] <= {ref_rd[WORD_W-1], ref_rd} - {upd_rd[WORD_W-1], upd_rd};
      end
      if (m_we) begin
         m_ff[i_ff][j_ff] <= sat_word;
      end
      if (d_we) begin
         d_ff[i_ff] <= sat_word;
      end
   end

   assign req_chan.ready    = (state_ff == ST_IDLE);
   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.pose_change = rsp_data_ff;

   `RPCM_ASSERT_NXT(a_compute_starts, clock, reset, req_accept && req_chan.command == CMD_COMPUTE, state_ff == ST_DIFF)
   `RPCM_ASSERT_NXT(a_mul_then_acc, clock, reset, state_ff == ST_MUL, state_ff == ST_ACC)
   `RPCM_ASSERT_NXT(a_send_loads_output, clock, reset, state_ff == ST_SEND && (!rsp_valid_ff || rsp_chan.ready), rsp_valid_ff && state_ff == ST_IDLE)

endmodule

`default_nettype wire

// ===== verif/rpcm_tb_channels.sv =====
// ----------------------------------------------------------------------------
// Testbench channel bundle
// Holds the counts of words that the testbench moves on the request and
// response channels; the channels themselves are declared in the testbench.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface rpcm_tb_bundle;
   import rpcm_pkg::*;

   // Counts of words moved on each side.
   int unsigned req_words;
   int unsigned rsp_words;
endinterface

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// Rigid pose change metric testbench
// Loads reference and updated poses element by element, issues compute
// commands and checks every result word against a bit-exact fixed-point
// predictor of the pose change metric, under random idling on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
   import rpcm_pkg::*;

   localparam int LIMIT_CYCLES = 3000000;
   localparam int SETTLE       = 400;

   typedef struct {
      logic [CMD_W-1:0]  cmd;
      logic [IDX_W-1:0]  idx;
      logic [WORD_W-1:0] val;
      bit                known;
      logic [OUT_W-1:0]  want;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   rpcm_req_if req_chan ();
   rpcm_rsp_if rsp_chan ();
   rpcm_tb_bundle stats ();

   rigid_pose_change_metric u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source)
   );

   // Predictor state: the two poses as the block should hold them.
   longint ref_pose [POSE_ELEMS];
   longint upd_pose [POSE_ELEMS];
   logic [OUT_W-1:0] change_queue [$];

   int unsigned mismatches = 0;
   int unsigned cycles = 0;
   int          send_idle = 25;
   int          recv_idle = 66;

   initial begin
      forever #6 clock = ~clock;
   end

   function automatic longint shr_floor(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint clip32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint unsigned root_floor(longint unsigned v);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   function automatic longint qmul(longint a, longint b);
      return shr_floor(a * b, FRAC_BITS);
   endfunction

   // Magnitude of the sine of atan2(y, x) by vectoring CORDIC.
   function automatic longint unsigned sine_mag(longint x, longint y);
      longint vx, vy, c, s, dx, dy, dc, ds;
      vx = (x < 0) ? -x : x;
      vy = (y < 0) ? -y : y;
      c = shr_floor(longint'(KINV_Q30), 30 - FRAC_BITS);
      s = 0;
      if (vx == 0 && vy == 0) return 0;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         dx = shr_floor(vy, i);
         dy = shr_floor(vx, i);
         dc = shr_floor(s, i);
         ds = shr_floor(c, i);
         if (vy >= 0) begin
            vx += dx; vy -= dy; c -= dc; s += ds;
         end else begin
            vx -= dx; vy += dy; c += dc; s -= ds;
         end
      end
      return (s < 0) ? -s : s;
   endfunction

   // Relative transform, Euler sines and translation norm.
   function automatic logic [OUT_W-1:0] pose_change_of();
      longint m [3][3];
      longint dt [3];
      longint df [3];
      longint a, x2, y2;
      longint unsigned s0, s1, s2, c2, sn, tn, sum;
      for (int k = 0; k < 3; k++) df[k] = ref_pose[k*4+3] - upd_pose[k*4+3];
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            a = 0;
            for (int k = 0; k < 3; k++) a += qmul(upd_pose[k*4+i], ref_pose[k*4+j]);
            m[i][j] = clip32(a);
         end
         a = 0;
         for (int k = 0; k < 3; k++) a += qmul(upd_pose[k*4+i], df[k]);
         dt[i] = clip32(a);
      end
      s0 = sine_mag(m[2][2], m[1][2]);
      c2 = root_floor(longint'(m[0][0] * m[0][0]) + longint'(m[0][1] * m[0][1]));
      s1 = sine_mag(longint'(c2), m[0][2]);
      // First angle zero: take the third angle straight from the matrix.
      if (m[1][2] == 0 && m[2][2] == 0) begin
         y2 = -m[1][0];
         x2 = m[1][1];
      end else begin
         y2 = qmul(m[1][2], m[2][0]) - qmul(m[2][2], m[1][0]);
         x2 = qmul(m[2][2], m[1][1]) - qmul(m[1][2], m[2][1]);
      end
      s2 = sine_mag(x2, y2);
      sn = root_floor(s0 * s0 + s1 * s1 + s2 * s2);
      tn = root_floor(dt[0] * dt[0] + dt[1] * dt[1] + dt[2] * dt[2]);
      sum = sn + tn;
      if (sum > 64'h7FFFFFFF) sum = 64'h7FFFFFFF;
      return sum[OUT_W-1:0];
   endfunction

   // Updates the predicted poses and queues any result the word causes.
   function automatic void predict_word(logic [CMD_W-1:0] cmd, logic [IDX_W-1:0] idx,
                                        logic [WORD_W-1:0] val);
      if ((cmd == CMD_LOAD_REF || cmd == CMD_LOAD_UPD) && idx < POSE_ELEMS) begin
         if (cmd == CMD_LOAD_REF) ref_pose[idx] = longint'(signed'(val));
         else upd_pose[idx] = longint'(signed'(val));
      end else if (cmd == CMD_COMPUTE) begin
         change_queue.push_back(pose_change_of());
      end
   endfunction

   // Called at a falling edge; returns at the falling edge after acceptance
   // with valid still high, so that a following word can go straight out.
   task automatic send_word(logic [CMD_W-1:0] cmd, logic [IDX_W-1:0] idx,
                            logic [WORD_W-1:0] val);
      while ($urandom_range(99) < send_idle) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.command <= cmd;
      req_chan.element_index <= idx;
      req_chan.element_value <= val;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      predict_word(cmd, idx, val);
      stats.req_words++;
      @(negedge clock);
   endtask

   // Near-rigid pose with random small rotation terms and translation, or fully random words when wild is set.
   task automatic load_pose(logic [CMD_W-1:0] cmd, bit wild);
      logic [WORD_W-1:0] v;
      for (int e = 0; e < POSE_ELEMS; e++) begin
         if (wild) v = $urandom;
         else if (e % 4 == 3) v = $urandom_range(0, 32'h0040_0000) - 32'h0020_0000;
         else if (e % 5 == 0) v = 32'h0001_0000 - $urandom_range(0, 32'h0000_4000);
         else v = $urandom_range(0, 32'h0000_8000) - 32'h0000_4000;
         send_word(cmd, e[IDX_W-1:0], v);
      end
   endtask

   // Result monitor: compares each accepted word with the oldest expectation.
   always @(posedge clock) begin
      logic [OUT_W-1:0] want;
      cycles++;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         stats.rsp_words++;
         if (change_queue.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("Unexpected result word: pose_change %h", rsp_chan.pose_change);
         end else begin
            want = change_queue.pop_front();
            if (rsp_chan.pose_change !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("Mismatch on pose_change: expected %h, actual %h",
                           want, rsp_chan.pose_change);
            end
         end
      end
      if (cycles >= LIMIT_CYCLES) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // Receiver stalls.
   always @(negedge clock) begin
      rsp_chan.ready <= ($urandom_range(99) >= recv_idle);
   end

   initial begin
      stim_row_type rows [$];
      stim_row_type r;
      int phase;
      int n;
      req_chan.valid = 1'b0;
      req_chan.command = CMD_LOAD_REF;
      req_chan.element_index = '0;
      req_chan.element_value = '0;
      rsp_chan.ready = 1'b0;
      stats.req_words = 0;
      stats.rsp_words = 0;
      for (int i = 0; i < POSE_ELEMS; i++) begin
         ref_pose[i] = 0;
         upd_pose[i] = 0;
      end
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed rows: reset poses give zero, unknown command and bad index
      // are dropped, extremes saturate.
      rows.push_back('{CMD_COMPUTE, 4'd0, 32'd0, 1, 31'd0});
      rows.push_back('{2'd3, 4'd5, 32'hFFFF_FFFF, 1, 31'd0});
      rows.push_back('{CMD_LOAD_REF, 4'd15, 32'h7FFF_FFFF, 0, '0});
      rows.push_back('{CMD_LOAD_UPD, 4'd12, 32'h8000_0000, 0, '0});
      rows.push_back('{CMD_COMPUTE, 4'd9, 32'd0, 1, 31'd0});
      rows.push_back('{CMD_LOAD_UPD, 4'd0, 32'h0001_0000, 0, '0});
      rows.push_back('{CMD_LOAD_UPD, 4'd5, 32'h0001_0000, 0, '0});
      rows.push_back('{CMD_LOAD_UPD, 4'd10, 32'h0001_0000, 0, '0});
      rows.push_back('{CMD_LOAD_REF, 4'd0, 32'h0001_0000, 0, '0});
      rows.push_back('{CMD_LOAD_REF, 4'd5, 32'h0001_0000, 0, '0});
      rows.push_back('{CMD_LOAD_REF, 4'd10, 32'h0001_0000, 0, '0});
      rows.push_back('{CMD_COMPUTE, 4'd0, 32'd0, 0, '0});
      rows.push_back('{CMD_LOAD_REF, 4'd3, 32'h0003_0000, 0, '0});
      rows.push_back('{CMD_COMPUTE, 4'd0, 32'd0, 0, '0});
      rows.push_back('{CMD_LOAD_REF, 4'd3, 32'h7FFF_FFFF, 0, '0});
      rows.push_back('{CMD_LOAD_UPD, 4'd3, 32'h8000_0000, 0, '0});
      rows.push_back('{CMD_LOAD_REF, 4'd7, 32'h7FFF_FFFF, 0, '0});
      rows.push_back('{CMD_LOAD_UPD, 4'd11, 32'h8000_0000, 0, '0});
      rows.push_back('{CMD_COMPUTE, 4'd0, 32'd0, 1, 31'h7FFF_FFFF});
      rows.push_back('{CMD_LOAD_REF, 4'd6, 32'h8000_0000, 0, '0});
      rows.push_back('{CMD_LOAD_UPD, 4'd6, 32'h7FFF_FFFF, 0, '0});
      rows.push_back('{CMD_COMPUTE, 4'd0, 32'd0, 0, '0});
      foreach (rows[i]) begin
         r = rows[i];
         send_word(r.cmd, r.idx, r.val);
         // A typed-in value must agree with the predictor's own answer.
         if (r.known && r.cmd == CMD_COMPUTE && change_queue[$] !== r.want) begin
            mismatches++;
            if (mismatches <= 10)
               $display("Directed row %0d: expected %h, predicted %h",
                        i, r.want, change_queue[$]);
         end
      end

      // Random part: three idling phases over pose sequences and noise.
      n = 0;
      for (phase = 0; phase < 3; phase++) begin
         send_idle = (phase == 0) ? 25 : (phase == 1) ? 66 : 0;
         recv_idle = (phase == 0) ? 66 : (phase == 1) ? 25 : 0;
         while (n < 520 * (phase + 1)) begin
            case ($urandom_range(9))
               0: begin
                  send_word(CMD_W'($urandom), IDX_W'($urandom), $urandom);
                  n++;
               end
               1: begin
                  load_pose(CMD_LOAD_REF, 1);
                  send_word(CMD_COMPUTE, IDX_W'($urandom), $urandom);
                  n += 13;
               end
               default: begin
                  load_pose(CMD_LOAD_REF, 0);
                  load_pose(CMD_LOAD_UPD, 0);
                  send_word(CMD_COMPUTE, IDX_W'($urandom), $urandom);
                  n += 25;
               end
            endcase
         end
      end
      req_chan.valid <= 1'b0;

      while (change_queue.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      if (mismatches == 0 && change_queue.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end
endmodule
